// ===== rtl/drc_pkg.sv =====
package drc_pkg;

   // operation codes of the request channel
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_POWER  = 3'd1;
   localparam logic [2:0] OP_KNOB   = 3'd2;
   localparam logic [2:0] OP_PRESET = 3'd3;
   localparam logic [2:0] OP_STORE  = 3'd4;

   // save timer request codes
   localparam logic [1:0] SAVE_NONE    = 2'd0;
   localparam logic [1:0] SAVE_RESTART = 2'd1;
   localparam logic [1:0] SAVE_CANCEL  = 2'd2;

   // register indexes of the csr port
   localparam logic [2:0] CSR_MIN_BRIGHTNESS     = 3'd0;
   localparam logic [2:0] CSR_MAX_BRIGHTNESS     = 3'd1;
   localparam logic [2:0] CSR_MAX_TEMP           = 3'd2;
   localparam logic [2:0] CSR_PRESET_FIRST       = 3'd3;
   localparam logic [2:0] CSR_PRESET_SECOND      = 3'd4;
   localparam logic [2:0] CSR_PRESET_THIRD       = 3'd5;
   localparam logic [2:0] CSR_DEFAULT_BRIGHTNESS = 3'd6;
   localparam logic [2:0] CSR_DEFAULT_TEMP       = 3'd7;

   // register reset values
   localparam logic [7:0] RST_MIN_BRIGHTNESS     = 8'd0;
   localparam logic [7:0] RST_MAX_BRIGHTNESS     = 8'd255;
   localparam logic [7:0] RST_MAX_TEMP           = 8'd255;
   localparam logic [7:0] RST_PRESET_FIRST       = 8'd64;
   localparam logic [7:0] RST_PRESET_SECOND      = 8'd128;
   localparam logic [7:0] RST_PRESET_THIRD       = 8'd192;
   localparam logic [7:0] RST_DEFAULT_BRIGHTNESS = 8'd128;
   localparam logic [7:0] RST_DEFAULT_TEMP       = 8'd128;

   localparam int DEFAULT_TEMP_STEPS = 256;

   // limit a temperature index to the top of the temperature table
   function automatic logic [7:0] temp_cap(input logic [7:0] value, input logic [7:0] top);
      temp_cap = (value > top) ? top : value;
   endfunction

   // one step of the current index toward its target
   function automatic logic [7:0] step_toward(input logic [7:0] cur, input logic [7:0] tgt);
      if (cur < tgt) begin
         step_toward = cur + 8'd1;
      end else if (cur > tgt) begin
         step_toward = cur - 8'd1;
      end else begin
         step_toward = cur;
      end
   endfunction

endpackage

// ===== rtl/dimmer_ramp_controller_unit.sv =====
// dimmer ramp controller
//
// request channel (req_*): one transaction carries an operation code (tick,
// power toggle, knob step, preset cycle, store) and two signed knob deltas.
// response channel (rsp_*): exactly one transaction per request, giving the
// current brightness and temperature indices, the power state, the refresh
// flag and the animation tick and save timer requests.
// csr port (csr_*): register index plus 8-bit data, always ready; writing a
// default register also loads the saved copy and the target of that value.
//
// a request accepted at an edge is shown on rsp_* from the next cycle on.
// throughput is one request per cycle while responses are taken; the state
// registers themselves form the single response register stage.
// while the receiver stalls, the held response keeps req_ready low; a new
// request enters in the same cycle the held response is taken.
// reset (synchronous, active high) turns the light off, clears the current
// indices, loads the csr defaults and empties the response register.
module dimmer_ramp_controller_unit #(
   parameter int TEMP_STEPS = drc_pkg::DEFAULT_TEMP_STEPS
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_operation,
   input  logic signed [15:0] req_brightness_delta,
   input  logic signed [15:0] req_temp_delta,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_brightness_level,
   output logic [7:0]        rsp_temp_level,
   output logic              rsp_refresh,
   output logic              rsp_power_on,
   output logic              rsp_tick_request,
   output logic [1:0]        rsp_save_timer,
   // csr write port
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_data
);

   // highest temperature index the table holds
   localparam logic [7:0] TEMP_TOP = 8'(TEMP_STEPS - 1);

   // csr registers
   logic [7:0] min_brightness_ff, max_brightness_ff, max_temp_ff;
   logic [7:0] preset_first_ff, preset_second_ff, preset_third_ff;

   // controller state
   logic       powered_ff, powered_in;
   logic [7:0] cur_bright_ff, cur_bright_in;
   logic [7:0] cur_temp_ff, cur_temp_in;
   logic [7:0] tgt_bright_ff, tgt_bright_in;
   logic [7:0] tgt_temp_ff, tgt_temp_in;
   logic [7:0] sav_bright_ff, sav_bright_in;
   logic [7:0] sav_temp_ff, sav_temp_in;

   // response register
   logic       rsp_valid_ff;
   logic       refresh_ff, refresh_in;
   logic       tick_ff, tick_in;
   logic [1:0] save_ff, save_in;

   logic req_accept;
   logic csr_write;

   // knob arithmetic, 18 bits signed covers 8-bit target plus 16-bit delta
   logic signed [17:0] knob_bright;
   logic signed [17:0] knob_temp;
   logic signed [17:0] min_b_ext, max_b_ext, temp_hi_ext;
   logic [7:0]         knob_bright_clamped;
   logic [7:0]         knob_temp_clamped;
   logic [7:0]         preset_next;
   logic               differs_after;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_brightness_level = cur_bright_ff;
   assign rsp_temp_level       = cur_temp_ff;
   assign rsp_refresh          = refresh_ff;
   assign rsp_power_on         = powered_ff;
   assign rsp_tick_request     = tick_ff;
   assign rsp_save_timer       = save_ff;

   // knob clamp: below the lower bound wins first, then the upper bound
   always_comb begin
      knob_bright = $signed({10'd0, tgt_bright_ff}) + 18'(req_brightness_delta);
      knob_temp   = $signed({10'd0, tgt_temp_ff}) + 18'(req_temp_delta);
      min_b_ext   = $signed({10'd0, min_brightness_ff});
      max_b_ext   = $signed({10'd0, max_brightness_ff});
      temp_hi_ext = $signed({10'd0, drc_pkg::temp_cap(max_temp_ff, TEMP_TOP)});

      if (knob_bright < min_b_ext) begin
         knob_bright_clamped = min_brightness_ff;
      end else if (knob_bright > max_b_ext) begin
         knob_bright_clamped = max_brightness_ff;
      end else begin
         knob_bright_clamped = knob_bright[7:0];
      end

      if (knob_temp < 18'sd0) begin
         knob_temp_clamped = 8'd0;
      end else if (knob_temp > temp_hi_ext) begin
         knob_temp_clamped = temp_hi_ext[7:0];
      end else begin
         knob_temp_clamped = knob_temp[7:0];
      end
   end

   // preset cycle: first, second, third, then wrap to first
   always_comb begin
      if (tgt_temp_ff < preset_first_ff || tgt_temp_ff >= preset_third_ff) begin
         preset_next = drc_pkg::temp_cap(preset_first_ff, TEMP_TOP);
      end else if (tgt_temp_ff < preset_second_ff) begin
         preset_next = drc_pkg::temp_cap(preset_second_ff, TEMP_TOP);
      end else begin
         preset_next = drc_pkg::temp_cap(preset_third_ff, TEMP_TOP);
      end
   end

   // next state and response flags for the request in hand
   always_comb begin
      powered_in    = powered_ff;
      cur_bright_in = cur_bright_ff;
      cur_temp_in   = cur_temp_ff;
      tgt_bright_in = tgt_bright_ff;
      tgt_temp_in   = tgt_temp_ff;
      sav_bright_in = sav_bright_ff;
      sav_temp_in   = sav_temp_ff;
      refresh_in    = 1'b0;
      tick_in       = 1'b0;
      save_in       = drc_pkg::SAVE_NONE;

      case (req_operation)
         drc_pkg::OP_TICK: begin
            cur_bright_in = drc_pkg::step_toward(cur_bright_ff, tgt_bright_ff);
            cur_temp_in   = drc_pkg::step_toward(cur_temp_ff, tgt_temp_ff);
            refresh_in    = (cur_bright_ff != tgt_bright_ff) || (cur_temp_ff != tgt_temp_ff);
            tick_in       = refresh_in;
         end
         drc_pkg::OP_POWER: begin
            save_in = drc_pkg::SAVE_CANCEL;
            if (powered_ff) begin
               powered_in    = 1'b0;
               tgt_bright_in = 8'd0;
            end else begin
               powered_in    = 1'b1;
               tgt_bright_in = sav_bright_ff;
               tgt_temp_in   = sav_temp_ff;
            end
         end
         drc_pkg::OP_KNOB: begin
            if (powered_ff) begin
               tgt_bright_in = knob_bright_clamped;
               tgt_temp_in   = knob_temp_clamped;
            end
         end
         drc_pkg::OP_PRESET: begin
            if (powered_ff) begin
               tgt_temp_in = preset_next;
            end
         end
         drc_pkg::OP_STORE: begin
            if (powered_ff) begin
               sav_bright_in = tgt_bright_ff;
               sav_temp_in   = tgt_temp_ff;
            end
         end
         default: begin
         end
      endcase

      // current indices only move on a tick, so compare against the old ones
      differs_after = (cur_bright_ff != tgt_bright_in) || (cur_temp_ff != tgt_temp_in);

      if (req_operation == drc_pkg::OP_POWER) begin
         tick_in = differs_after;
      end else if ((req_operation == drc_pkg::OP_KNOB || req_operation == drc_pkg::OP_PRESET)
                   && powered_ff && differs_after) begin
         tick_in = 1'b1;
         save_in = drc_pkg::SAVE_RESTART;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_brightness_ff     <= drc_pkg::RST_MIN_BRIGHTNESS;
         max_brightness_ff     <= drc_pkg::RST_MAX_BRIGHTNESS;
         max_temp_ff           <= drc_pkg::RST_MAX_TEMP;
         preset_first_ff       <= drc_pkg::RST_PRESET_FIRST;
         preset_second_ff      <= drc_pkg::RST_PRESET_SECOND;
         preset_third_ff       <= drc_pkg::RST_PRESET_THIRD;
         powered_ff            <= 1'b0;
         cur_bright_ff         <= 8'd0;
         cur_temp_ff           <= 8'd0;
         tgt_bright_ff         <= drc_pkg::RST_DEFAULT_BRIGHTNESS;
         sav_bright_ff         <= drc_pkg::RST_DEFAULT_BRIGHTNESS;
         tgt_temp_ff           <= drc_pkg::temp_cap(drc_pkg::RST_DEFAULT_TEMP, TEMP_TOP);
         sav_temp_ff           <= drc_pkg::temp_cap(drc_pkg::RST_DEFAULT_TEMP, TEMP_TOP);
         rsp_valid_ff          <= 1'b0;
         refresh_ff            <= 1'b0;
         tick_ff               <= 1'b0;
         save_ff               <= drc_pkg::SAVE_NONE;
      end else begin
         // response slot empties when taken, refills on a new request
         if (req_accept) begin
            rsp_valid_ff  <= 1'b1;
            powered_ff    <= powered_in;
            cur_bright_ff <= cur_bright_in;
            cur_temp_ff   <= cur_temp_in;
            tgt_bright_ff <= tgt_bright_in;
            tgt_temp_ff   <= tgt_temp_in;
            sav_bright_ff <= sav_bright_in;
            sav_temp_ff   <= sav_temp_in;
            refresh_ff    <= refresh_in;
            tick_ff       <= tick_in;
            save_ff       <= save_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // csr writes come last so a default write lands on target and saved copy
         if (csr_write) begin
            case (csr_index)
               drc_pkg::CSR_MIN_BRIGHTNESS: min_brightness_ff <= csr_data;
               drc_pkg::CSR_MAX_BRIGHTNESS: max_brightness_ff <= csr_data;
               drc_pkg::CSR_MAX_TEMP:       max_temp_ff       <= csr_data;
               drc_pkg::CSR_PRESET_FIRST:   preset_first_ff   <= csr_data;
               drc_pkg::CSR_PRESET_SECOND:  preset_second_ff  <= csr_data;
               drc_pkg::CSR_PRESET_THIRD:   preset_third_ff   <= csr_data;
               drc_pkg::CSR_DEFAULT_BRIGHTNESS: begin
                  tgt_bright_ff <= csr_data;
                  sav_bright_ff <= csr_data;
               end
               drc_pkg::CSR_DEFAULT_TEMP: begin
                  tgt_temp_ff <= drc_pkg::temp_cap(csr_data, TEMP_TOP);
                  sav_temp_ff <= drc_pkg::temp_cap(csr_data, TEMP_TOP);
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TEMP_STEPS = drc_pkg::DEFAULT_TEMP_STEPS;
   localparam logic [7:0] TEMP_TOP = 8'(TEMP_STEPS - 1);

   // codes the block must ignore
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS = 200;

   typedef struct packed {
      logic [7:0] level;
      logic [7:0] temp;
      logic       refresh;
      logic       power;
      logic       tick;
      logic [1:0] save;
   } dimmer_result_type;

   // predicts each response of the dimmer and holds the ones not yet seen
   class dimmer_scoreboard_type;
      logic [7:0] min_b, max_b, max_t;
      logic [7:0] preset_a, preset_b, preset_c;
      logic [7:0] dflt_b, dflt_t;
      logic       on;
      logic [7:0] cur_b, cur_t, tgt_b, tgt_t, sav_b, sav_t;
      dimmer_result_type expected_q[$];
      int errors;

      function new();
         min_b = drc_pkg::RST_MIN_BRIGHTNESS;
         max_b = drc_pkg::RST_MAX_BRIGHTNESS;
         max_t = drc_pkg::RST_MAX_TEMP;
         preset_a = drc_pkg::RST_PRESET_FIRST;
         preset_b = drc_pkg::RST_PRESET_SECOND;
         preset_c = drc_pkg::RST_PRESET_THIRD;
         dflt_b = drc_pkg::RST_DEFAULT_BRIGHTNESS;
         dflt_t = drc_pkg::RST_DEFAULT_TEMP;
         on = 1'b0;
         cur_b = 8'd0;
         cur_t = 8'd0;
         tgt_b = dflt_b;
         sav_b = dflt_b;
         tgt_t = cap_temp(dflt_t);
         sav_t = cap_temp(dflt_t);
         errors = 0;
      endfunction

      function logic [7:0] cap_temp(logic [7:0] v);
         return (v > TEMP_TOP) ? TEMP_TOP : v;
      endfunction

      function logic ramp_pending();
         return (cur_b != tgt_b) || (cur_t != tgt_t);
      endfunction

      function void write_reg(logic [2:0] index, logic [7:0] value);
         case (index)
            drc_pkg::CSR_MIN_BRIGHTNESS: min_b = value;
            drc_pkg::CSR_MAX_BRIGHTNESS: max_b = value;
            drc_pkg::CSR_MAX_TEMP: max_t = value;
            drc_pkg::CSR_PRESET_FIRST: preset_a = value;
            drc_pkg::CSR_PRESET_SECOND: preset_b = value;
            drc_pkg::CSR_PRESET_THIRD: preset_c = value;
            drc_pkg::CSR_DEFAULT_BRIGHTNESS: begin
               dflt_b = value;
               tgt_b = value;
               sav_b = value;
            end
            drc_pkg::CSR_DEFAULT_TEMP: begin
               dflt_t = value;
               tgt_t = cap_temp(value);
               sav_t = cap_temp(value);
            end
            default: ;
         endcase
      endfunction

      function void note_request(logic [2:0] op, logic signed [15:0] b_delta,
                                 logic signed [15:0] t_delta);
         dimmer_result_type r;
         int b_sum, t_sum, t_hi;
         r = '0;
         case (op)
            drc_pkg::OP_TICK: begin
               if (cur_t != tgt_t) begin
                  cur_t = (cur_t < tgt_t) ? cur_t + 8'd1 : cur_t - 8'd1;
                  r.refresh = 1'b1;
               end
               if (cur_b != tgt_b) begin
                  cur_b = (cur_b < tgt_b) ? cur_b + 8'd1 : cur_b - 8'd1;
                  r.refresh = 1'b1;
               end
               r.tick = r.refresh;
            end
            drc_pkg::OP_POWER: begin
               r.save = drc_pkg::SAVE_CANCEL;
               if (on) begin
                  tgt_b = 8'd0;
                  on = 1'b0;
               end else begin
                  on = 1'b1;
                  tgt_t = sav_t;
                  tgt_b = sav_b;
               end
               r.tick = ramp_pending();
            end
            drc_pkg::OP_KNOB: begin
               if (on) begin
                  b_sum = int'(tgt_b) + int'(b_delta);
                  t_sum = int'(tgt_t) + int'(t_delta);
                  t_hi = int'(cap_temp(max_t));
                  // lower bound tested first, so a sum below min stays at min
                  if (b_sum < int'(min_b)) b_sum = int'(min_b);
                  else if (b_sum > int'(max_b)) b_sum = int'(max_b);
                  if (t_sum < 0) t_sum = 0;
                  else if (t_sum > t_hi) t_sum = t_hi;
                  tgt_b = 8'(b_sum);
                  tgt_t = 8'(t_sum);
                  if (ramp_pending()) begin
                     r.tick = 1'b1;
                     r.save = drc_pkg::SAVE_RESTART;
                  end
               end
            end
            drc_pkg::OP_PRESET: begin
               if (on) begin
                  if (tgt_t < preset_a || tgt_t >= preset_c) tgt_t = cap_temp(preset_a);
                  else if (tgt_t < preset_b) tgt_t = cap_temp(preset_b);
                  else tgt_t = cap_temp(preset_c);
                  if (ramp_pending()) begin
                     r.tick = 1'b1;
                     r.save = drc_pkg::SAVE_RESTART;
                  end
               end
            end
            drc_pkg::OP_STORE: begin
               if (on) begin
                  sav_t = tgt_t;
                  sav_b = tgt_b;
               end
            end
            default: ;
         endcase
         r.level = cur_b;
         r.temp = cur_t;
         r.power = on;
         expected_q.push_back(r);
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_response(dimmer_result_type got);
         dimmer_result_type want;
         if (expected_q.size() == 0) begin
            report("response with nothing expected");
         end else begin
            want = expected_q.pop_front();
            if (got.level !== want.level)
               report($sformatf("brightness_level %0d, expected %0d", got.level, want.level));
            if (got.temp !== want.temp)
               report($sformatf("temp_level %0d, expected %0d", got.temp, want.temp));
            if (got.refresh !== want.refresh)
               report($sformatf("refresh %b, expected %b", got.refresh, want.refresh));
            if (got.power !== want.power)
               report($sformatf("power_on %b, expected %b", got.power, want.power));
            if (got.tick !== want.tick)
               report($sformatf("tick_request %b, expected %b", got.tick, want.tick));
            if (got.save !== want.save)
               report($sformatf("save_timer %0d, expected %0d", got.save, want.save));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [2:0] req_operation;
   logic signed [15:0] req_brightness_delta;
   logic signed [15:0] req_temp_delta;
   logic rsp_valid;
   logic rsp_ready;
   logic [7:0] rsp_brightness_level;
   logic [7:0] rsp_temp_level;
   logic rsp_refresh;
   logic rsp_power_on;
   logic rsp_tick_request;
   logic [1:0] rsp_save_timer;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [7:0] csr_data;

   dimmer_scoreboard_type sb;
   // raised by the stimulus, taken by the receiver process
   bit hold_off_request;

   dimmer_ramp_controller_unit #(
      .TEMP_STEPS(TEMP_STEPS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_brightness_delta(req_brightness_delta),
      .req_temp_delta(req_temp_delta),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_brightness_level(rsp_brightness_level),
      .rsp_temp_level(rsp_temp_level),
      .rsp_refresh(rsp_refresh),
      .rsp_power_on(rsp_power_on),
      .rsp_tick_request(rsp_tick_request),
      .rsp_save_timer(rsp_save_timer),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // every transaction seen at the edge, on the values from before the edge
   always @(posedge clock) begin : monitor
      dimmer_result_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (rsp_valid && rsp_ready) begin
            got.level = rsp_brightness_level;
            got.temp = rsp_temp_level;
            got.refresh = rsp_refresh;
            got.power = rsp_power_on;
            got.tick = rsp_tick_request;
            got.save = rsp_save_timer;
            sb.check_response(got);
         end
         if (req_valid && req_ready)
            sb.note_request(req_operation, req_brightness_delta, req_temp_delta);
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // knob steps: mostly small, some large, some at the 16-bit extremes
   function automatic logic [15:0] random_delta();
      int r = $urandom_range(0, 99);
      if (r < 40) return 16'($urandom_range(0, 12)) - 16'd6;
      if (r < 70) return 16'($urandom_range(0, 800)) - 16'd400;
      if (r < 80) return ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7fff;
      return 16'($urandom);
   endfunction

   // register values leaning toward the ends of the range
   function automatic logic [7:0] random_reg();
      int r = $urandom_range(0, 99);
      if (r < 12) return 8'd0;
      if (r < 24) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_request(logic [2:0] op, logic [15:0] b_delta, logic [15:0] t_delta,
                               int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_brightness_delta <= b_delta;
      req_temp_delta <= t_delta;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_request(bit burst);
      int pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 40) op = drc_pkg::OP_TICK;
      else if (pick < 65) op = drc_pkg::OP_KNOB;
      else if (pick < 73) op = drc_pkg::OP_POWER;
      else if (pick < 85) op = drc_pkg::OP_PRESET;
      else if (pick < 97) op = drc_pkg::OP_STORE;
      else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      send_request(op, random_delta(), random_delta(), burst ? 0 : idle_gap());
   endtask

   // stop offering and wait until every response is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [7:0] min_b, logic [7:0] max_b, logic [7:0] max_t,
                            logic [7:0] pa, logic [7:0] pb, logic [7:0] pc,
                            logic [7:0] db, logic [7:0] dt);
      write_reg(drc_pkg::CSR_MIN_BRIGHTNESS, min_b);
      write_reg(drc_pkg::CSR_MAX_BRIGHTNESS, max_b);
      write_reg(drc_pkg::CSR_MAX_TEMP, max_t);
      write_reg(drc_pkg::CSR_PRESET_FIRST, pa);
      write_reg(drc_pkg::CSR_PRESET_SECOND, pb);
      write_reg(drc_pkg::CSR_PRESET_THIRD, pc);
      write_reg(drc_pkg::CSR_DEFAULT_BRIGHTNESS, db);
      write_reg(drc_pkg::CSR_DEFAULT_TEMP, dt);
   endtask

   // receiver: ready bursts with random idle stretches, one long hold-off on request
   initial begin : receiver
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         n = ($urandom_range(0, 9) < 2) ? $urandom_range(30, 80) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (n) @(posedge clock);
         n = idle_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin : stimulus
      sb = new();
      hold_off_request = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= drc_pkg::OP_TICK;
      req_brightness_delta <= '0;
      req_temp_delta <= '0;
      csr_valid <= 1'b0;
      csr_index <= drc_pkg::CSR_MIN_BRIGHTNESS;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on the reset settings
      send_request(drc_pkg::OP_TICK, 16'h0000, 16'h0000, idle_gap());   // ramps even while off
      send_request(drc_pkg::OP_KNOB, 16'd100, 16'd100, idle_gap());     // ignored while off
      send_request(drc_pkg::OP_PRESET, 16'h0000, 16'h0000, idle_gap()); // ignored while off
      send_request(drc_pkg::OP_STORE, 16'h0000, 16'h0000, idle_gap());  // no copy while off
      send_request(drc_pkg::OP_POWER, 16'h0000, 16'h0000, idle_gap());
      send_request(drc_pkg::OP_KNOB, 16'h7fff, 16'h7fff, idle_gap());   // clamps at the top
      send_request(drc_pkg::OP_TICK, 16'hffff, 16'hffff, idle_gap());
      send_request(drc_pkg::OP_KNOB, 16'h8000, 16'h8000, idle_gap());   // clamps at the bottom
      send_request(drc_pkg::OP_KNOB, 16'h0000, 16'h0000, idle_gap());
      send_request(drc_pkg::OP_PRESET, 16'h0000, 16'h0000, idle_gap());
      send_request(drc_pkg::OP_PRESET, 16'h0000, 16'h0000, idle_gap());
      send_request(drc_pkg::OP_PRESET, 16'h0000, 16'h0000, idle_gap());
      // wraps to the first preset
      send_request(drc_pkg::OP_PRESET, 16'h0000, 16'h0000, idle_gap());
      send_request(drc_pkg::OP_STORE, 16'h0000, 16'h0000, idle_gap());
      send_request(drc_pkg::OP_KNOB, 16'h5555, 16'haaaa, idle_gap());
      send_request(drc_pkg::OP_TICK, 16'h0000, 16'h0000, idle_gap());
      // off drops brightness target
      send_request(drc_pkg::OP_POWER, 16'h0000, 16'h0000, idle_gap());
      send_request(drc_pkg::OP_TICK, 16'h0000, 16'h0000, idle_gap());
      // on restores saved targets
      send_request(drc_pkg::OP_POWER, 16'h0000, 16'h0000, idle_gap());
      send_request(OP_SPARE_LO, 16'h1234, 16'h4321, idle_gap());
      send_request(OP_SPARE_LO + 3'd1, 16'hffff, 16'h0000, idle_gap());
      send_request(OP_SPARE_HI, 16'hffff, 16'hffff, idle_gap());
      send_request(drc_pkg::OP_STORE, 16'h0000, 16'h0000, idle_gap());
      send_request(drc_pkg::OP_TICK, 16'h0000, 16'h0000, idle_gap());

      // random phases, each on its own register setting
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               // min above max, temperature pinned at zero
               configure(8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
            end
            1: begin
               configure(8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255);
               hold_off_request = 1'b1;
            end
            2: begin
               configure(drc_pkg::RST_MIN_BRIGHTNESS, drc_pkg::RST_MAX_BRIGHTNESS,
                         drc_pkg::RST_MAX_TEMP, drc_pkg::RST_PRESET_FIRST,
                         drc_pkg::RST_PRESET_SECOND, drc_pkg::RST_PRESET_THIRD,
                         drc_pkg::RST_DEFAULT_BRIGHTNESS, drc_pkg::RST_DEFAULT_TEMP);
            end
            default: begin
               configure(8'($urandom_range(0, 60)), 8'($urandom_range(120, 255)),
                         random_reg(), random_reg(), random_reg(), random_reg(),
                         random_reg(), random_reg());
            end
         endcase
         // phases three and six run without any idle cycles on the sender
         for (int i = 0; i < PHASE_ITEMS; i++) random_request(phase == 3 || phase == 6);
      end

      wait_idle();
      repeat (5) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("PASS dimmer_ramp_controller_unit");
      end else begin
         $display("FAIL dimmer_ramp_controller_unit");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin : watchdog
      #10_000_000;
      $display("FAIL dimmer_ramp_controller_unit");
      $finish;
   end

endmodule
